@@ rtl/hehc_pkg.sv @@
// ----------------------------------------------------------------------------
// hehc_pkg
// Shared constants, types and the slot hash of the hashed entry hit counter.
// ----------------------------------------------------------------------------
package hehc_pkg;

    localparam int TABLE_SLOTS = 8192;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int USED_W      = SLOT_W + 1;
    localparam int SEL_W       = 13;
    localparam int KEY_W       = 32;
    localparam int HIT_W       = 64;
    localparam int USED_OUT_W  = 14;
    localparam int CNT_W       = 32;
    localparam int CMP_W       = (USED_W > SEL_W) ? USED_W : SEL_W;

    localparam logic [KEY_W-1:0] HASH_MULT        = 32'd2654435761;
    localparam logic [CNT_W-1:0] DEFAULT_INTERVAL = 32'd20000000;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic mem_rd;
        logic res_read;
        logic res_hit;
        logic res_ins;
        logic res_drop;
        logic probe_next;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic is_read;
        logic hit;
        logic empty;
        logic last_probe;
        logic out_free;
    } t_ctrl_stat;

    // low bits of the product only depend on the low bits of the operands
    function automatic t_slot slot_hash(input logic [KEY_W-1:0] addr);
        logic [2*SLOT_W-1:0] prod;
        prod = addr[SLOT_W-1:0] * HASH_MULT[SLOT_W-1:0];
        return prod[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/hehc_if.sv @@
// ----------------------------------------------------------------------------
// hehc channel interfaces
// Valid/ready channels for input items, results and the interval register.
// ----------------------------------------------------------------------------
interface hehc_in_if import hehc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [KEY_W-1:0] address;
    logic [SEL_W-1:0] slot_select;

    modport source (output valid, command, address, slot_select, input ready);
    modport sink (input valid, command, address, slot_select, output ready);
endinterface

interface hehc_out_if import hehc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SEL_W-1:0]      slot;
    logic [KEY_W-1:0]      entry_address;
    logic [HIT_W-1:0]      hit_count;
    logic                  inserted;
    logic                  dropped;
    logic                  report_due;
    logic [USED_OUT_W-1:0] entries_used;
    logic                  table_full;

    modport source (
        output valid, slot, entry_address, hit_count, inserted, dropped,
               report_due, entries_used, table_full,
        input  ready
    );
    modport sink (
        input  valid, slot, entry_address, hit_count, inserted, dropped,
               report_due, entries_used, table_full,
        output ready
    );
endinterface

interface hehc_cfg_if import hehc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] report_interval;

    modport source (output valid, report_interval, input ready);
    modport sink (input valid, report_interval, output ready);
endinterface

@@ rtl/hashed_entry_hit_counter.sv @@
// ----------------------------------------------------------------------------
// hashed_entry_hit_counter
// Per-address hit counter in an open addressing table with linear probing.
// ----------------------------------------------------------------------------
// flow: an item is taken in ST_IDLE and probed in ST_READ and ST_CHECK, once for
//   a read and once or more for a count; each probe is one read and one check of the store
// items: the next item is taken only once the last result is loaded for output
// reset: the hit store is swept to zero, input not ready
//   meanwhile; interval writes are taken at all times
module hashed_entry_hit_counter import hehc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hehc_in_if.sink    i_in,
    hehc_out_if.source o_out,
    hehc_cfg_if.sink   i_cfg
);

    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    hehc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (ctrl_stat),
        .o_cmd   (ctrl_cmd)
    );

    hehc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (ctrl_cmd),
        .o_stat  (ctrl_stat)
    );

endmodule

@@ rtl/hehc_ram.sv @@
// ----------------------------------------------------------------------------
// hehc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hehc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hehc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hehc_ctrl
// Sequencer for clearing, slot probing and result hand-off.
// ----------------------------------------------------------------------------
module hehc_ctrl import hehc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_stat.is_read) begin
                    o_cmd.res_read = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = ST_DONE;
                end else if (i_stat.empty) begin
                    o_cmd.res_ins = 1'b1;
                    n_state       = ST_DONE;
                end else if (i_stat.last_probe) begin
                    o_cmd.res_drop = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = ST_READ;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/hehc_dpath.sv @@
// ----------------------------------------------------------------------------
// hehc_dpath
// Key and hit stores, probe pointer, counters and result registers.
// ----------------------------------------------------------------------------
module hehc_dpath import hehc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hehc_in_if.sink     i_in,
    hehc_out_if.source  o_out,
    hehc_cfg_if.sink    i_cfg,
    input  t_ctrl_cmd   i_cmd,
    output t_ctrl_stat  o_stat
);

    logic              r_cmd;
    logic [KEY_W-1:0]  r_addr;
    logic [SEL_W-1:0]  r_sel;
    logic              r_sel_ok;
    t_slot             r_probe;
    t_slot             r_nprobe;
    logic              r_due;
    logic [CNT_W-1:0]  r_calls;
    logic [CNT_W-1:0]  r_interval;
    logic [USED_W-1:0] r_used;
    logic              r_full;
    t_slot             r_clr;

    logic [SEL_W-1:0]  r_res_slot;
    logic [KEY_W-1:0]  r_res_key;
    logic [HIT_W-1:0]  r_res_hits;
    logic              r_res_ins;
    logic              r_res_drop;
    logic              r_res_due;

    logic              r_out_valid;
    logic [SEL_W-1:0]  r_out_slot;
    logic [KEY_W-1:0]  r_out_key;
    logic [HIT_W-1:0]  r_out_hits;
    logic              r_out_ins;
    logic              r_out_drop;
    logic              r_out_due;
    logic [USED_W-1:0] r_out_used;
    logic              r_out_full;

    logic              accept;
    logic [CNT_W-1:0]  interval_eff;
    logic [CNT_W-1:0]  calls_inc;
    logic              due_now;
    logic              sel_ok;

    t_slot             mem_addr;
    logic              key_we;
    logic              hit_we;
    logic [HIT_W-1:0]  hit_wdata;
    logic [KEY_W-1:0]  key_q;
    logic [HIT_W-1:0]  hit_q;
    logic [HIT_W-1:0]  hit_inc;
    logic              out_take;

    assign accept       = i_cmd.in_ready && i_in.valid;
    assign interval_eff = (r_interval > CNT_W'(1)) ? r_interval : DEFAULT_INTERVAL;
    assign calls_inc    = r_calls + CNT_W'(1);
    assign due_now      = (calls_inc >= interval_eff);
    assign sel_ok       = (CMP_W'(i_in.slot_select) < CMP_W'(TABLE_SLOTS));
    assign hit_inc      = (hit_q == '1) ? hit_q : hit_q + HIT_W'(1);
    assign out_take     = r_out_valid && o_out.ready;

    // store port control
    assign mem_addr  = i_cmd.clr_wr ? r_clr : r_probe;
    assign key_we    = i_cmd.res_ins;
    assign hit_we    = i_cmd.clr_wr || i_cmd.res_hit || i_cmd.res_ins;
    assign hit_wdata = i_cmd.clr_wr ? '0 : (i_cmd.res_ins ? HIT_W'(1) : hit_inc);

    hehc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mem_rd || key_we),
        .i_we    (key_we),
        .i_addr  (mem_addr),
        .i_wdata (r_addr),
        .o_rdata (key_q)
    );

    hehc_ram #(
        .WIDTH (HIT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_hit_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mem_rd || hit_we),
        .i_we    (hit_we),
        .i_addr  (mem_addr),
        .i_wdata (hit_wdata),
        .o_rdata (hit_q)
    );

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.clr_last   = (r_clr == t_slot'(TABLE_SLOTS - 1));
    assign o_stat.is_read    = (r_cmd == CMD_READ);
    assign o_stat.hit        = (hit_q != '0) && (key_q == r_addr);
    assign o_stat.empty      = (hit_q == '0);
    assign o_stat.last_probe = (r_nprobe == t_slot'(TABLE_SLOTS - 1));
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calls     <= '0;
            r_interval  <= DEFAULT_INTERVAL;
            r_used      <= '0;
            r_full      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_interval <= i_cfg.report_interval;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + t_slot'(1);
            end
            if (accept && (i_in.command == CMD_COUNT)) begin
                r_calls <= due_now ? '0 : calls_inc;
            end
            if (i_cmd.res_ins) begin
                r_used <= r_used + USED_W'(1);
            end
            if (i_cmd.res_drop) begin
                r_full <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_in.command;
            r_addr   <= i_in.address;
            r_sel    <= i_in.slot_select;
            r_sel_ok <= sel_ok;
            r_nprobe <= '0;
            r_due    <= (i_in.command == CMD_COUNT) && due_now;
            r_probe  <= (i_in.command == CMD_READ) ? t_slot'(i_in.slot_select)
                                                   : slot_hash(i_in.address);
        end else if (i_cmd.probe_next) begin
            r_probe  <= r_probe + t_slot'(1);
            r_nprobe <= r_nprobe + t_slot'(1);
        end

        if (i_cmd.res_read) begin
            r_res_slot <= r_sel;
            r_res_key  <= (r_sel_ok && hit_q != '0) ? key_q : '0;
            r_res_hits <= r_sel_ok ? hit_q : '0;
            r_res_ins  <= 1'b0;
            r_res_drop <= 1'b0;
            r_res_due  <= 1'b0;
        end else if (i_cmd.res_hit || i_cmd.res_ins) begin
            r_res_slot <= SEL_W'(r_probe);
            r_res_key  <= r_addr;
            r_res_hits <= i_cmd.res_ins ? HIT_W'(1) : hit_inc;
            r_res_ins  <= i_cmd.res_ins;
            r_res_drop <= 1'b0;
            r_res_due  <= r_due;
        end else if (i_cmd.res_drop) begin
            r_res_slot <= '0;
            r_res_key  <= '0;
            r_res_hits <= '0;
            r_res_ins  <= 1'b0;
            r_res_drop <= 1'b1;
            r_res_due  <= r_due;
        end

        if (i_cmd.load_out) begin
            r_out_slot <= r_res_slot;
            r_out_key  <= r_res_key;
            r_out_hits <= r_res_hits;
            r_out_ins  <= r_res_ins;
            r_out_drop <= r_res_drop;
            r_out_due  <= r_res_due;
            r_out_used <= r_used;
            r_out_full <= r_full;
        end
    end

    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.slot          = r_out_slot;
    assign o_out.entry_address = r_out_key;
    assign o_out.hit_count     = r_out_hits;
    assign o_out.inserted      = r_out_ins;
    assign o_out.dropped       = r_out_drop;
    assign o_out.report_due    = r_out_due;
    assign o_out.entries_used  = USED_OUT_W'(r_out_used);
    assign o_out.table_full    = r_out_full;

endmodule

@@ rtl/hehc_checker.sv @@
// ----------------------------------------------------------------------------
// hehc_checker
// Port-level checks of the hashed entry hit counter, bound to the top level.
// ----------------------------------------------------------------------------
module hehc_checker import hehc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [HIT_W-1:0] i_hit_count,
    input  logic             i_inserted,
    input  logic             i_dropped,
    input  logic             i_table_full,
    input  logic [USED_OUT_W-1:0] i_entries_used
);

    // one item in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready after transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit_count))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |=> !i_out_valid || i_table_full)
        else $error("full flag cleared");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped |-> i_table_full && !i_inserted && i_hit_count == '0)
        else $error("bad dropped result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inserted |-> i_hit_count == HIT_W'(1) && i_entries_used != '0)
        else $error("bad inserted result");

endmodule

bind hashed_entry_hit_counter hehc_checker u_hehc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_hit_count    (o_out.hit_count),
    .i_inserted     (o_out.inserted),
    .i_dropped      (o_out.dropped),
    .i_table_full   (o_out.table_full),
    .i_entries_used (o_out.entries_used)
);

@@ test/hehc_checker.sv @@
// ----------------------------------------------------------------------------
// hehc_scoreboard
// Watches the item, result and interval channels of the hit counter. Keeps
// its own slot table, report counter and interval, works out the result of
// every accepted item and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module hehc_scoreboard import hehc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hehc_in_if   i_in,
    hehc_out_if  i_out,
    hehc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_in_flight
);

    typedef struct packed {
        logic [SEL_W-1:0]      slot;
        logic [KEY_W-1:0]      entry_address;
        logic [HIT_W-1:0]      hit_count;
        logic                  inserted;
        logic                  dropped;
        logic                  report_due;
        logic [USED_OUT_W-1:0] entries_used;
        logic                  table_full;
    } t_tally;

    logic [KEY_W-1:0]      key_store [TABLE_SLOTS];
    logic [HIT_W-1:0]      hit_store [TABLE_SLOTS];
    logic [USED_OUT_W-1:0] occupied_count;
    logic                  full_seen;
    logic [CNT_W-1:0]      counts_since_due;
    logic [CNT_W-1:0]      interval_reg;
    t_tally                tallies_in_flight [$];
    int                    fails;

    function automatic t_tally tally(input logic cmd, input logic [KEY_W-1:0] addr,
                                     input logic [SEL_W-1:0] sel);
        t_tally           r;
        logic [CNT_W-1:0] limit;
        logic [CNT_W:0]   next;
        logic [KEY_W-1:0] mix;
        int unsigned      home;
        int unsigned      k;
        logic             found;
        r = '0;
        if (cmd == CMD_READ) begin
            r.slot = sel;
            if (int'(sel) < TABLE_SLOTS && hit_store[sel] != '0) begin
                r.entry_address = key_store[sel];
                r.hit_count     = hit_store[sel];
            end
            r.entries_used = occupied_count;
            r.table_full   = full_seen;
            return r;
        end
        // interval of 0 or 1 falls back to the default
        limit = (interval_reg > 32'd1) ? interval_reg : DEFAULT_INTERVAL;
        next  = {1'b0, counts_since_due} + 33'd1;
        if (next >= {1'b0, limit}) begin
            r.report_due     = 1'b1;
            counts_since_due = '0;
        end else begin
            counts_since_due = next[CNT_W-1:0];
        end
        mix   = addr * HASH_MULT;
        home  = mix % TABLE_SLOTS;
        found = 1'b0;
        for (int unsigned n = 0; n < TABLE_SLOTS && !found; n++) begin
            k = (home + n) % TABLE_SLOTS;
            if (hit_store[k] != '0 && key_store[k] == addr) begin
                if (hit_store[k] != '1)
                    hit_store[k] = hit_store[k] + 64'd1;
                r.slot          = SEL_W'(k);
                r.entry_address = addr;
                r.hit_count     = hit_store[k];
                found           = 1'b1;
            end else if (hit_store[k] == '0) begin
                key_store[k]    = addr;
                hit_store[k]    = 64'd1;
                occupied_count  = occupied_count + USED_OUT_W'(1);
                r.slot          = SEL_W'(k);
                r.entry_address = addr;
                r.hit_count     = 64'd1;
                r.inserted      = 1'b1;
                found           = 1'b1;
            end
        end
        if (!found) begin
            full_seen = 1'b1;
            r.dropped = 1'b1;
        end
        r.entries_used = occupied_count;
        r.table_full   = full_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [HIT_W-1:0] want,
                               input logic [HIT_W-1:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= 100)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_tally want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                key_store[i] = '0;
                hit_store[i] = '0;
            end
            occupied_count   = '0;
            full_seen        = 1'b0;
            counts_since_due = '0;
            interval_reg     = DEFAULT_INTERVAL;
            tallies_in_flight.delete();
            fails = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (tallies_in_flight.size() == 0) begin
                    fails++;
                    if (fails <= 100)
                        $display(
                            "%0t: extra result, expected none, actual slot %0h hit_count %0h",
                            $time, i_out.slot, i_out.hit_count);
                end else begin
                    want = tallies_in_flight.pop_front();
                    check_field("slot", HIT_W'(want.slot), HIT_W'(i_out.slot));
                    check_field("entry_address", HIT_W'(want.entry_address),
                                HIT_W'(i_out.entry_address));
                    check_field("hit_count", want.hit_count, i_out.hit_count);
                    check_field("inserted", HIT_W'(want.inserted), HIT_W'(i_out.inserted));
                    check_field("dropped", HIT_W'(want.dropped), HIT_W'(i_out.dropped));
                    check_field("report_due", HIT_W'(want.report_due), HIT_W'(i_out.report_due));
                    check_field("entries_used", HIT_W'(want.entries_used),
                                HIT_W'(i_out.entries_used));
                    check_field("table_full", HIT_W'(want.table_full), HIT_W'(i_out.table_full));
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                interval_reg = i_cfg.report_interval;
            if (i_in.valid && i_in.ready)
                tallies_in_flight.push_back(tally(i_in.command, i_in.address, i_in.slot_select));
        end
        o_fail_count <= fails;
        o_in_flight  <= tallies_in_flight.size();
    end

endmodule

@@ test/tb_hashed_entry_hit_counter.sv @@
// ----------------------------------------------------------------------------
// tb_hashed_entry_hit_counter
// Drives the hit counter with directed counts and reads, then random segments
// under several report intervals with random idling on both sides and one long
// result hold-off; the third and the last segment run without idling.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hashed_entry_hit_counter;
    import hehc_pkg::*;

    localparam int TAG_W        = KEY_W - SLOT_W;
    localparam int SEGMENTS     = 5;
    localparam int SEG_ITEMS    = 380;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_AFTER   = 600;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int QUIET_LIMIT  = 100000;
    localparam int CLUSTER_BASE = 3000;

    logic             clk = 1'b0;
    logic             rst_n;
    int               fail_count;
    int               in_flight;
    bit               sender_gaps;
    bit               receiver_stalls;
    logic [KEY_W-1:0] pool [POOL_SIZE];

    hehc_in_if  in_ch ();
    hehc_out_if out_ch ();
    hehc_cfg_if cfg_ch ();

    hashed_entry_hit_counter DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hehc_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_in_flight  (in_flight)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // key whose hash lands on the given home slot
    function automatic logic [KEY_W-1:0] key_homed_at(input int unsigned home,
                                                      input logic [TAG_W-1:0] tag);
        logic [KEY_W-1:0] inv;
        logic [KEY_W-1:0] prod;
        inv = HASH_MULT;
        repeat (4) inv = inv * (32'd2 - HASH_MULT * inv);
        prod = home * inv;
        return {tag, prod[SLOT_W-1:0]};
    endfunction

    task automatic push_item(input logic cmd, input logic [KEY_W-1:0] addr,
                             input logic [SEL_W-1:0] sel);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.address     <= addr;
        in_ch.slot_select <= sel;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic count_address(input logic [KEY_W-1:0] addr);
        push_item(CMD_COUNT, addr, SEL_W'($urandom_range(0, TABLE_SLOTS - 1)));
    endtask

    task automatic read_slot(input logic [SEL_W-1:0] sel);
        push_item(CMD_READ, $urandom, sel);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic write_interval(input logic [CNT_W-1:0] value);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.report_interval <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        int results_seen;
        bit held;
        stall_left   = 0;
        results_seen = 0;
        held         = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                results_seen++;
            if (!held && results_seen >= HOLD_AFTER) begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] w1;
        logic [KEY_W-1:0] w2;
        logic [KEY_W-1:0] w3;
        logic [KEY_W-1:0] addr;
        int               pick;
        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.command          <= CMD_COUNT;
        in_ch.address          <= '0;
        in_ch.slot_select      <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.report_interval <= '0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        k0 = key_homed_at(0, TAG_W'(1));
        w1 = key_homed_at(TABLE_SLOTS - 1, TAG_W'(2));
        w2 = key_homed_at(TABLE_SLOTS - 1, TAG_W'(3));
        w3 = key_homed_at(TABLE_SLOTS - 1, TAG_W'(4));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        // directed: smallest interval, probing, wrap at the table end, reads
        write_interval(32'd2);
        count_address(k0);
        count_address(k0);
        count_address(32'h0000_0000);
        count_address(32'hFFFF_FFFF);
        count_address(w1);
        count_address(w2);
        count_address(w3);
        count_address(w3);
        read_slot(SEL_W'(0));
        read_slot(SEL_W'(TABLE_SLOTS - 1));
        read_slot(SEL_W'(3));
        read_slot(SEL_W'(4000));
        drain();
        write_interval(32'd0);
        count_address(32'h8000_0000);
        count_address(k0);
        count_address(32'h7FFF_FFFF);
        drain();
        write_interval(32'd1);
        count_address(k0);
        count_address(w1);
        drain();
        write_interval(32'hFFFF_FFFF);
        repeat (4) count_address($urandom);
        drain();
        // interval below the running count fires on the next count
        write_interval(32'd2);
        count_address(w2);
        count_address(32'h0000_1FFF);

        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = $urandom;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg)
                0: write_interval(32'd3);
                1: write_interval(32'd1);
                2: write_interval(32'd17);
                3: write_interval(32'd2);
                default: write_interval(32'd9);
            endcase
            sender_gaps     = (seg != 2 && seg != SEGMENTS - 1);
            receiver_stalls = (seg != 2 && seg != SEGMENTS - 1);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    read_slot(SEL_W'($urandom_range(0, TABLE_SLOTS - 1)));
                end else if (pick < 15) begin
                    read_slot(SEL_W'($urandom_range(CLUSTER_BASE - 8, CLUSTER_BASE + 200)));
                end else if (pick < 65) begin
                    count_address(pool[$urandom_range(0, POOL_SIZE - 1)]);
                end else begin
                    // a few keys share home slots to build probe chains
                    if (pick < 72)
                        addr = key_homed_at($urandom_range(CLUSTER_BASE, CLUSTER_BASE + 7),
                                            TAG_W'($urandom));
                    else
                        addr = $urandom;
                    pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
                    count_address(addr);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && in_flight == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
